// ----- rtl/core/bal_pkg.sv -----
// ============================================================================
// Buddy allocator package
// Shared constants: pool defaults, field widths, result status codes and request types.
// ============================================================================
package bal_pkg;

  localparam int POOL_LOG_DEF = 10;

  // Width of the pool size register and its value after reset.
  localparam int TSW = 11;
  localparam logic [TSW-1:0] TOTAL_RESET = 11'd1024;

  // Fixed widths of the request and result fields.
  localparam int START_W = 10;
  localparam int ID_W    = 32;
  localparam int REQ_W   = 16;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_NOPOW2  = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // Request types.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

endpackage

// ----- rtl/core/bal_ram.sv -----
// ============================================================================
// Generic RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module bal_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/buddy_allocator.sv -----
// ============================================================================
// Binary buddy allocator
// Allocates and frees power-of-two blocks of a pool, with ids for grants.
// ============================================================================
// A request is taken when start is high and busy is low; exactly one result
// beat follows on out_valid some cycles later, and it must be taken in that
// cycle because the receiver cannot stall it. The block takes no new request
// until it has given the result of the last one: it rounds the size and finds
// a fitting order, scans the live table (the lowest free slot on allocate, the
// matching id on free), moves the later free-list entries down when an entry
// leaves a list, and on free searches a list for the buddy at each merge.
// The scans and moves go through the single read port of the free-list
// memory or of the live-table memory. After reset and after every write of
// the size register, a clearing pass over every slot empties the live table;
// busy is high during it, while register writes are still taken.
// ============================================================================
module buddy_allocator
  import bal_pkg::*;
#(
  parameter int POOL_LOG = POOL_LOG_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Request beat.
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [REQ_W-1:0]   in_req_size,
  input  logic [ID_W-1:0]    in_free_id,
  // Result beat.
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [ID_W-1:0]    out_grant_id,
  output logic [START_W-1:0] out_grant_start,
  output logic [TSW-1:0]     out_grant_size,
  // Size register write.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TSW-1:0]     cfg_total_size
);

  // Address width, order index width, and order counter width (one past top).
  localparam int AW   = POOL_LOG;
  localparam int OW   = $clog2(POOL_LOG + 1);
  localparam int KW   = $clog2(POOL_LOG + 2);
  localparam int NORD = 1 << OW;
  localparam int CW   = AW + 1;
  localparam int FLD  = 1 << (OW + AW);
  localparam int LTD  = 1 << AW;

  typedef struct packed {
    logic            vld;
    logic [ID_W-1:0] id;
    logic [AW-1:0]   start;
    logic [OW-1:0]   ord;
  } live_t;

  localparam int LW = $bits(live_t);

  typedef enum logic [15:0] {
    S_CLEAR   = 16'h0001,
    S_IDLE    = 16'h0002,
    S_RND     = 16'h0004,
    S_FIT     = 16'h0008,
    S_SLT_RD  = 16'h0010,
    S_SLT_CK  = 16'h0020,
    S_HEAD_RD = 16'h0040,
    S_HEAD_CK = 16'h0080,
    S_RM_RD   = 16'h0100,
    S_RM_WR   = 16'h0200,
    S_SPLIT   = 16'h0400,
    S_FID_RD  = 16'h0800,
    S_FID_CK  = 16'h1000,
    S_MRG     = 16'h2000,
    S_BSR_RD  = 16'h4000,
    S_BSR_CK  = 16'h8000
  } state_t;

  state_t state_r;

  // Pool description, taken from the size register when it is written or at reset.
  logic          pool_ok_r;
  logic [OW-1:0] top_r;

  // Per-order fill counts of the free lists.
  logic [CW-1:0] cnt_r [NORD];

  // Request context and working registers.
  logic            typ_r;
  logic [ID_W-1:0] fid_r;
  logic [ID_W-1:0] id_r;
  logic [REQ_W-1:0] sz_r;
  logic [KW-1:0]   k_r;
  logic [KW-1:0]   ord_r;
  logic [AW-1:0]   slot_r;
  logic [CW-1:0]   pos_r;
  logic [AW-1:0]   addr_r;
  logic [AW-1:0]   clr_r;

  // Result registers.
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [ID_W-1:0]    out_grant_id_r;
  logic [START_W-1:0] out_grant_start_r;
  logic [TSW-1:0]     out_grant_size_r;

  // Memory ports.
  logic                fl_we;
  logic [OW+AW-1:0]    fl_waddr;
  logic [AW-1:0]       fl_wdata;
  logic [OW+AW-1:0]    fl_raddr;
  logic [AW-1:0]       fl_rdata;
  logic                lt_we;
  logic [AW-1:0]       lt_waddr;
  logic [LW-1:0]       lt_wdata;
  logic [LW-1:0]       lt_rdata;
  live_t               lt_rd;

  // Derived values.
  logic [TSW-1:0] cfg_src;
  logic           n_ok;
  logic [OW-1:0]  n_top;
  logic           cfg_fire;
  logic [KW-1:0]  top_k;
  logic [OW-1:0]  oi;
  logic [KW-1:0]  om1;
  logic [OW-1:0]  omi;
  logic [AW-1:0]  bit_o;
  logic [AW-1:0]  bit_m1;
  logic [CW-1:0]  pos_p1;
  logic           fid_hit;
  logic           append;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign busy      = (state_r != S_IDLE);

  // Pool size decode: a power of two no larger than the address space.
  assign cfg_src = rst_n ? cfg_total_size : TOTAL_RESET;

  always_comb begin
    n_ok  = (cfg_src != '0) && ((cfg_src & (cfg_src - 1'b1)) == '0) &&
            (32'(cfg_src) <= (32'd1 << POOL_LOG));
    n_top = '0;
    for (int b = 0; b < TSW; b++) begin
      if (n_ok && cfg_src[b]) begin
        n_top = OW'(b);
      end
    end
  end

  assign top_k   = KW'(top_r);
  assign oi      = ord_r[OW-1:0];
  assign om1     = ord_r - 1'b1;
  assign omi     = om1[OW-1:0];
  assign bit_o   = AW'(1) << ord_r;
  assign bit_m1  = AW'(1) << om1;
  assign pos_p1  = pos_r + 1'b1;
  assign lt_rd   = live_t'(lt_rdata);
  assign fid_hit = lt_rd.vld && (lt_rd.id == fid_r);

  // A merged or unmatched block goes to the back of its order's list.
  assign append = ((state_r == S_MRG) && !(ord_r < top_k)) ||
                  ((state_r == S_BSR_RD) && !(pos_r < cnt_r[oi]));

  // Memory port control.
  always_comb begin
    fl_we    = 1'b0;
    fl_waddr = {oi, cnt_r[oi][AW-1:0]};
    fl_wdata = addr_r;
    fl_raddr = {oi, pos_r[AW-1:0]};
    lt_we    = 1'b0;
    lt_waddr = slot_r;
    lt_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        lt_we    = 1'b1;
        lt_waddr = clr_r;
        // The single starting block sits at address zero of the top order.
        fl_we    = pool_ok_r;
        fl_waddr = {top_r, {AW{1'b0}}};
        fl_wdata = '0;
      end
      S_HEAD_RD: begin
        fl_raddr = {oi, {AW{1'b0}}};
      end
      S_RM_RD: begin
        fl_raddr = {oi, pos_p1[AW-1:0]};
      end
      S_RM_WR: begin
        fl_we    = 1'b1;
        fl_waddr = {oi, pos_r[AW-1:0]};
        fl_wdata = fl_rdata;
      end
      S_SPLIT: begin
        if (ord_r > k_r) begin
          fl_we    = !cnt_r[omi][AW];
          fl_waddr = {omi, cnt_r[omi][AW-1:0]};
          fl_wdata = addr_r | bit_m1;
        end else begin
          lt_we    = 1'b1;
          lt_wdata = live_t'{vld: 1'b1, id: id_r, start: addr_r, ord: k_r[OW-1:0]};
        end
      end
      S_FID_CK: begin
        lt_we = fid_hit;
      end
      S_MRG, S_BSR_RD: begin
        fl_we = append && !cnt_r[oi][AW];
      end
      default: begin
      end
    endcase
  end

  bal_ram #(
    .W(AW),
    .D(FLD)
  ) u_free_lists (
    .clk  (clk),
    .we   (fl_we),
    .waddr(fl_waddr),
    .wdata(fl_wdata),
    .raddr(fl_raddr),
    .rdata(fl_rdata)
  );

  bal_ram #(
    .W(LW),
    .D(LTD)
  ) u_live_table (
    .clk  (clk),
    .we   (lt_we),
    .waddr(lt_waddr),
    .wdata(lt_wdata),
    .raddr(slot_r),
    .rdata(lt_rdata)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_fire) begin
      // Restart: empty every list but the top one and sweep the live table.
      state_r     <= S_CLEAR;
      pool_ok_r   <= n_ok;
      top_r       <= n_top;
      for (int o = 0; o < NORD; o++) begin
        cnt_r[o] <= '0;
      end
      cnt_r[n_top] <= CW'(n_ok);
      id_r        <= ID_W'(1);
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == {AW{1'b1}}) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (start) begin
            typ_r  <= in_req_type;
            fid_r  <= in_free_id;
            slot_r <= '0;
            if (in_req_type == REQ_FREE) begin
              state_r <= S_FID_RD;
            end else if (!pool_ok_r) begin
              out_valid_r       <= 1'b1;
              out_status_r      <= ST_NOPOW2;
              out_grant_id_r    <= '0;
              out_grant_start_r <= '0;
              out_grant_size_r  <= '0;
            end else begin
              // The order is the bit length of size minus one (zero counts as one).
              sz_r    <= (in_req_size == '0) ? '0 : in_req_size - 1'b1;
              k_r     <= '0;
              state_r <= S_RND;
            end
          end
        end

        S_RND: begin
          if ((sz_r != '0) && (k_r <= top_k)) begin
            sz_r <= sz_r >> 1;
            k_r  <= k_r + 1'b1;
          end else begin
            ord_r   <= k_r;
            state_r <= S_FIT;
          end
        end

        S_FIT: begin
          if (ord_r > top_k) begin
            out_valid_r       <= 1'b1;
            out_status_r      <= ST_NOSPACE;
            out_grant_id_r    <= '0;
            out_grant_start_r <= '0;
            out_grant_size_r  <= '0;
            state_r           <= S_IDLE;
          end else if (cnt_r[oi] == '0) begin
            ord_r <= ord_r + 1'b1;
          end else begin
            state_r <= S_SLT_RD;
          end
        end

        S_SLT_RD: begin
          state_r <= S_SLT_CK;
        end

        S_SLT_CK: begin
          if (!lt_rd.vld) begin
            state_r <= S_HEAD_RD;
          end else if (slot_r == {AW{1'b1}}) begin
            out_valid_r       <= 1'b1;
            out_status_r      <= ST_NOSPACE;
            out_grant_id_r    <= '0;
            out_grant_start_r <= '0;
            out_grant_size_r  <= '0;
            state_r           <= S_IDLE;
          end else begin
            slot_r  <= slot_r + 1'b1;
            state_r <= S_SLT_RD;
          end
        end

        S_HEAD_RD: begin
          state_r <= S_HEAD_CK;
        end

        S_HEAD_CK: begin
          addr_r  <= fl_rdata;
          pos_r   <= '0;
          state_r <= S_RM_RD;
        end

        // Entry removal: every later entry of the list moves down one place.
        S_RM_RD: begin
          if (pos_p1 < cnt_r[oi]) begin
            state_r <= S_RM_WR;
          end else begin
            cnt_r[oi] <= cnt_r[oi] - 1'b1;
            if (typ_r == REQ_FREE) begin
              addr_r  <= addr_r & ~bit_o;
              ord_r   <= ord_r + 1'b1;
              state_r <= S_MRG;
            end else begin
              state_r <= S_SPLIT;
            end
          end
        end

        S_RM_WR: begin
          pos_r   <= pos_p1;
          state_r <= S_RM_RD;
        end

        S_SPLIT: begin
          if (ord_r > k_r) begin
            ord_r <= om1;
            if (!cnt_r[omi][AW]) begin
              cnt_r[omi] <= cnt_r[omi] + 1'b1;
            end
          end else begin
            out_valid_r       <= 1'b1;
            out_status_r      <= ST_DONE;
            out_grant_id_r    <= id_r;
            out_grant_start_r <= START_W'(addr_r);
            out_grant_size_r  <= TSW'(1) << k_r;
            id_r              <= id_r + 1'b1;
            state_r           <= S_IDLE;
          end
        end

        S_FID_RD: begin
          state_r <= S_FID_CK;
        end

        S_FID_CK: begin
          if (fid_hit) begin
            ord_r   <= KW'(lt_rd.ord);
            addr_r  <= lt_rd.start;
            state_r <= S_MRG;
          end else if (slot_r == {AW{1'b1}}) begin
            out_valid_r       <= 1'b1;
            out_status_r      <= ST_UNKNOWN;
            out_grant_id_r    <= '0;
            out_grant_start_r <= '0;
            out_grant_size_r  <= '0;
            state_r           <= S_IDLE;
          end else begin
            slot_r  <= slot_r + 1'b1;
            state_r <= S_FID_RD;
          end
        end

        S_MRG: begin
          if (ord_r < top_k) begin
            pos_r   <= '0;
            state_r <= S_BSR_RD;
          end
        end

        S_BSR_RD: begin
          if (pos_r < cnt_r[oi]) begin
            state_r <= S_BSR_CK;
          end
        end

        S_BSR_CK: begin
          if (fl_rdata == (addr_r ^ bit_o)) begin
            state_r <= S_RM_RD;
          end else begin
            pos_r   <= pos_p1;
            state_r <= S_BSR_RD;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // Merging has stopped: the block joins its list and the free completes.
      if (append) begin
        if (!cnt_r[oi][AW]) begin
          cnt_r[oi] <= cnt_r[oi] + 1'b1;
        end
        out_valid_r       <= 1'b1;
        out_status_r      <= ST_DONE;
        out_grant_id_r    <= '0;
        out_grant_start_r <= '0;
        out_grant_size_r  <= '0;
        state_r           <= S_IDLE;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_grant_id    = out_grant_id_r;
  assign out_grant_start = out_grant_start_r;
  assign out_grant_size  = out_grant_size_r;

endmodule
